[rtl/core/pip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int COORD_WIDTH_DEF  = 16;

  localparam int CMD_W    = 2;
  localparam int VCOUNT_W = 6;
  localparam int M_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESP
  } pip_state_t;

  // Control from the sequencer to the edge unit.
  typedef struct packed {
    logic start;      // clears the inside flag for a new query
    logic vtx_vld;    // a vertex arrives from the memory
    logic vtx_first;  // the arriving vertex only opens the first edge
  } pip_edge_ctl_t;

  // Status from the edge unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic in_poly;
  } pip_edge_st_t;

endpackage

[rtl/core/pip_vertex_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_vertex_mem
// Vertex table: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module pip_vertex_mem #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/pip_edge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge_unit
// Crossing test of one polygon edge per cycle, pipelined over three stages.
// ----------------------------------------------------------------------------
module pip_edge_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pip_pkg::pip_edge_ctl_t        ctl,
  input  logic signed [COORD_WIDTH-1:0] vtx_x,
  input  logic signed [COORD_WIDTH-1:0] vtx_y,
  input  logic signed [COORD_WIDTH-1:0] pt_x,
  input  logic signed [COORD_WIDTH-1:0] pt_y,
  output pip_pkg::pip_edge_st_t         st
);

  import pip_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] prev_x;
  logic signed [COORD_WIDTH-1:0] prev_y;

  logic signed [DW-1:0] dxp_c, dy_c, dxe_c, dyp_c;
  logic                 strad_c;

  logic                 vld1;
  logic                 strad1;
  logic signed [DW-1:0] dxp1, dy1, dxe1, dyp1;

  logic                 vld2;
  logic                 strad2;
  logic                 dy_neg2;
  logic signed [PW-1:0] lhs2, rhs2;

  logic                 hit;
  logic                 in_flag;

  // The arriving vertex is i, the held one is j of the edge (j, i).
  always_comb begin
    dxp_c   = {pt_x[COORD_WIDTH-1], pt_x} - {vtx_x[COORD_WIDTH-1], vtx_x};
    dy_c    = {prev_y[COORD_WIDTH-1], prev_y} - {vtx_y[COORD_WIDTH-1], vtx_y};
    dxe_c   = {prev_x[COORD_WIDTH-1], prev_x} - {vtx_x[COORD_WIDTH-1], vtx_x};
    dyp_c   = {pt_y[COORD_WIDTH-1], pt_y} - {vtx_y[COORD_WIDTH-1], vtx_y};
    strad_c = (vtx_y > pt_y) != (prev_y > pt_y);
  end

  always_ff @(posedge clk) begin
    if (ctl.vtx_vld) begin
      prev_x <= vtx_x;
      prev_y <= vtx_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= ctl.vtx_vld && !ctl.vtx_first;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    strad1 <= strad_c;
    dxp1   <= dxp_c;
    dy1    <= dy_c;
    dxe1   <= dxe_c;
    dyp1   <= dyp_c;
  end

  always_ff @(posedge clk) begin
    strad2  <= strad1;
    dy_neg2 <= dy1[DW-1];
    lhs2    <= dxp1 * dy1;
    rhs2    <= dxe1 * dyp1;
  end

  // A straddling edge never has a zero y span, so the sign bit picks the side.
  assign hit = dy_neg2 ? (rhs2 < lhs2) : (lhs2 < rhs2);

  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      in_flag <= 1'b0;
    end else if (vld2 && strad2 && hit) begin
      in_flag <= !in_flag;
    end
  end

  assign st.busy    = vld1 || vld2;
  assign st.in_poly = in_flag;

endmodule

[rtl/core/point_in_polygon_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Vertex table with even-odd point containment queries.
// ----------------------------------------------------------------------------
// Each input transaction carries a command in s_tuser and a point in s_tdata;
// each one returns exactly one output transaction. A query against n stored
// vertices reads the vertex memory one vertex per cycle through its single
// read port, n + 1 reads in all, followed by the three-stage edge pipeline
// and the result state; a query on an empty table reads nothing. A new
// transaction is accepted while the previous result still waits on the
// output register.
module point_in_polygon_test #(
  parameter int  MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int  COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF,
  localparam int S_DATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [S_DATA_W-1:0]        s_tdata,   // x_coord, y_coord, zero pad
  input  logic [pip_pkg::CMD_W-1:0]  s_tuser,   // command
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [pip_pkg::M_DATA_W-1:0] m_tdata  // inside_res, vertex_count, status
);

  import pip_pkg::*;

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VW     = 2 * COORD_WIDTH;

  pip_state_t state, state_next;

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       rd_idx;
  logic                   rd_vld;
  logic                   rd_first;
  logic [CMD_W-1:0]       cmd_q;
  logic                   res_status;
  logic signed [COORD_WIDTH-1:0] pt_x, pt_y;

  logic                   in_acc;
  logic                   full;
  logic                   out_free;
  logic                   rd_en;
  logic                   rd_last;
  logic [CNT_W-1:0]       rd_addr_full;
  logic                   load_out;
  logic [VW-1:0]          rd_data;
  logic [CNT_W+VCOUNT_W-1:0] count_ext;

  pip_edge_ctl_t          ectl;
  pip_edge_st_t           est;

  assign in_acc   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(MAX_VERTICES));
  assign out_free = !m_tvalid || m_tready;
  assign rd_last  = (rd_idx == count);

  // Reads run n-1, 0, 1, ..., n-1 so the closing edge comes first.
  assign rd_addr_full = ((rd_idx == '0) ? count : rd_idx) - CNT_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser == CMD_QUERY && count != '0) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_WALK: begin
        if (rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !est.busy) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    rd_en          = 1'b0;
    load_out       = 1'b0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_WALK:  rd_en    = 1'b1;
      ST_DRAIN: ;
      ST_RESP:  load_out = out_free;
      default:  ;
    endcase
    ectl.start     = in_acc && (s_tuser == CMD_QUERY);
    ectl.vtx_vld   = rd_vld;
    ectl.vtx_first = rd_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_idx   <= '0;
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= rd_en;
      rd_first <= rd_en && (rd_idx == '0);
      if (in_acc) begin
        rd_idx <= '0;
        if (s_tuser == CMD_CLEAR) begin
          count <= '0;
        end else if (s_tuser == CMD_APPEND && !full) begin
          count <= count + CNT_W'(1);
        end
      end else if (rd_en) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q      <= s_tuser;
      res_status <= (s_tuser == CMD_APPEND) && full;
      pt_x       <= s_tdata[COORD_WIDTH-1:0];
      pt_y       <= s_tdata[VW-1:COORD_WIDTH];
    end
  end

  assign count_ext = {{VCOUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {res_status, count_ext[VCOUNT_W-1:0],
                  (cmd_q == CMD_QUERY) && est.in_poly};
    end
  end

  pip_vertex_mem #(
    .DEPTH  (MAX_VERTICES),
    .DATA_W (VW)
  ) u_mem (
    .clk   (clk),
    .we    (in_acc && (s_tuser == CMD_APPEND) && !full),
    .waddr (count[ADDR_W-1:0]),
    .wdata (s_tdata[VW-1:0]),
    .re    (rd_en),
    .raddr (rd_addr_full[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  pip_edge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ectl),
    .vtx_x (rd_data[COORD_WIDTH-1:0]),
    .vtx_y (rd_data[VW-1:COORD_WIDTH]),
    .pt_x  (pt_x),
    .pt_y  (pt_y),
    .st    (est)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count exceeds table depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (rd_idx <= count))
    else $error("read index ran past the vertex count");

  a_read_in_query: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_WALK || state == ST_DRAIN))
    else $error("read data returned outside a query");

  a_edge_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_RESP) |-> !est.busy)
    else $error("edge pipeline still busy after a query ended");

  a_empty_outside: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser == CMD_QUERY && count == '0) |=> (state == ST_RESP))
    else $error("empty-table query did not answer at once");
`endif

endmodule

[bench/polygon_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_checker
// Predicts and checks the results of the point-in-polygon block.
// ----------------------------------------------------------------------------
// Each accepted input transaction is applied to a private copy of the vertex
// table. The result it must produce goes into an in-order queue, and each
// output transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module polygon_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // x_coord, y_coord
  input  logic [1:0]  s_tuser,   // command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // inside_res, vertex_count, status
  output int          fail_count,
  output int          pending
);
  import pip_pkg::*;

  localparam int TABLE_DEPTH = MAX_VERTICES_DEF;

  typedef struct packed {
    logic       in_poly;
    logic [5:0] count;
    logic       status;
  } poly_result_t;

  logic signed [15:0] poly_x [TABLE_DEPTH];
  logic signed [15:0] poly_y [TABLE_DEPTH];
  int                 poly_len;
  poly_result_t       results_q [$];
  int                 errors;

  // Even-odd crossing test. Coordinate differences fit in 17 bits, so the
  // cross products are exact in 64-bit arithmetic.
  function automatic logic point_inside(logic signed [15:0] px, logic signed [15:0] py);
    logic   flag;
    int     i;
    int     j;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    logic   hit;
    flag = 1'b0;
    if (poly_len == 0) return 1'b0;
    j = poly_len - 1;
    for (i = 0; i < poly_len; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > longint'(py)) != (yj > longint'(py))) begin
        dy  = yj - yi;
        lhs = (longint'(px) - xi) * dy;
        rhs = (xj - xi) * (longint'(py) - yi);
        hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (hit) flag = ~flag;
      end
      j = i;
    end
    return flag;
  endfunction

  function automatic poly_result_t apply_command(logic [1:0] cmd, logic signed [15:0] x,
                                                 logic signed [15:0] y);
    poly_result_t r;
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        poly_len = 0;
      end
      CMD_APPEND: begin
        if (poly_len < TABLE_DEPTH) begin
          poly_x[poly_len] = x;
          poly_y[poly_len] = y;
          poly_len++;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_QUERY: begin
        r.in_poly = point_inside(x, y);
      end
      default: begin
      end
    endcase
    r.count = poly_len[5:0];
    return r;
  endfunction

  always @(posedge clk) begin
    poly_result_t want;
    poly_result_t got;
    if (rst) begin
      results_q.delete();
      poly_len = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.in_poly = m_tdata[0];
        got.count   = m_tdata[6:1];
        got.status  = m_tdata[7];
        if (results_q.size() == 0) begin
          errors++;
          $display("%0t: expected no transaction, got inside=%0d count=%0d status=%0d",
                   $time, got.in_poly, got.count, got.status);
        end else begin
          want = results_q.pop_front();
          if (want != got) begin
            errors++;
            $display("%0t: mismatch: expected inside=%0d count=%0d status=%0d,",
                     $time, want.in_poly, want.count, want.status,
                     " got inside=%0d count=%0d status=%0d",
                     got.in_poly, got.count, got.status);
          end
        end
      end
      if (s_tvalid && s_tready)
        results_q.insert(results_q.size(),
                         apply_command(s_tuser, s_tdata[15:0], s_tdata[31:16]));
    end
    pending    <= results_q.size();
    fail_count <= errors;
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the point-in-polygon block.
// ----------------------------------------------------------------------------
// A directed pass covers the empty table, degenerate polygons, a polygon on
// the coordinate extremes, boundary points and the unused command. Random
// polygons follow, from small to overfull, each probed by several queries,
// under three patterns of source and sink stalls.
// ----------------------------------------------------------------------------
module testbench;
  import pip_pkg::*;

  localparam int S_DATA_W     = ((2 * COORD_WIDTH_DEF + 7) / 8) * 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 500;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [CMD_W-1:0]    s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int quiet_cycles;

  // Recent vertices, used to put query points on vertex rows and columns.
  logic signed [15:0] recent_x [$];
  logic signed [15:0] recent_y [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_in_polygon_test uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  polygon_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run if the block stops moving transactions in either direction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[point_in_polygon_test] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [15:0] x,
                           logic signed [15:0] y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == CMD_APPEND) begin
      recent_x.insert(recent_x.size(), x);
      recent_y.insert(recent_y.size(), y);
      if (recent_x.size() > 40) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
      end
    end
  endtask

  // Holds the source off until every outstanding result has been returned.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [15:0] near_coord(int center, int radius);
    int v;
    v = center + $urandom_range(2 * radius) - radius;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] any_coord();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic polygon_round();
    int n_vertices;
    int n_queries;
    int cx, cy, radius;
    int k;
    int pick;
    logic signed [15:0] qx, qy;
    if ($urandom_range(9) != 0) send_item(CMD_CLEAR, any_coord(), any_coord());
    case ($urandom_range(19))
      0, 1, 2:    n_vertices = $urandom_range(0, 2);
      3, 4, 5:    n_vertices = $urandom_range(28, 36);
      default:    n_vertices = $urandom_range(3, 10);
    endcase
    case ($urandom_range(3))
      0:       radius = 12;
      1:       radius = 300;
      2:       radius = 6000;
      default: radius = 32768;
    endcase
    cx = $signed(16'($urandom));
    cy = $signed(16'($urandom));
    if (radius == 32768) begin
      cx = 0;
      cy = 0;
    end
    for (k = 0; k < n_vertices; k++)
      send_item(CMD_APPEND, near_coord(cx, radius), near_coord(cy, radius));
    n_queries = $urandom_range(2, 8);
    for (k = 0; k < n_queries; k++) begin
      qx = near_coord(cx, radius + radius / 4);
      qy = near_coord(cy, radius + radius / 4);
      if (recent_x.size() != 0 && $urandom_range(3) == 0) begin
        pick = $urandom_range(recent_x.size() - 1);
        if ($urandom_range(1)) qy = recent_y[pick];
        else                   qx = recent_x[pick];
        if ($urandom_range(3) == 0) begin
          qx = recent_x[pick];
          qy = recent_y[pick];
        end
      end
      send_item(CMD_QUERY, qx, qy);
    end
  endtask

  task automatic random_phase(int stop_at);
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 8)
        send_item(CMD_W'($urandom_range(3)), any_coord(), any_coord());
      else
        polygon_round();
    end
    drain_results();
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = CMD_CLEAR;
    send_idle_pct = 22;
    recv_idle_pct = 84;
    items_sent    = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty table, then the unused command.
    send_item(CMD_QUERY, 16'sh0000, 16'sh0000);
    send_item(CMD_UNUSED, 16'sh7fff, 16'sh8000);
    // Square on the extremes of the coordinate range.
    send_item(CMD_APPEND, 16'sh8000, 16'sh8000);
    send_item(CMD_APPEND, 16'sh7fff, 16'sh8000);
    send_item(CMD_APPEND, 16'sh7fff, 16'sh7fff);
    send_item(CMD_APPEND, 16'sh8000, 16'sh7fff);
    send_item(CMD_QUERY, 16'sh0000, 16'sh0000);
    send_item(CMD_QUERY, 16'sh8000, 16'sh0000);
    send_item(CMD_QUERY, 16'sh7fff, 16'sh0000);
    send_item(CMD_QUERY, 16'sh0000, 16'sh8000);
    send_item(CMD_QUERY, 16'sh0000, 16'sh7fff);
    send_item(CMD_QUERY, 16'sh7fff, 16'sh7fff);
    send_item(CMD_QUERY, 16'sh7ffe, 16'sh8001);
    send_item(CMD_UNUSED, 16'sh0000, 16'sh0000);
    // Clearing keeps stale entries that must not influence later queries.
    send_item(CMD_CLEAR, 16'sh1234, 16'sh5678);
    send_item(CMD_QUERY, 16'sh0000, 16'sh0000);
    // One and two vertices.
    send_item(CMD_APPEND, 16'sh0010, 16'sh0010);
    send_item(CMD_QUERY, 16'sh0010, 16'sh0010);
    send_item(CMD_APPEND, 16'shfff0, 16'shffe0);
    send_item(CMD_QUERY, 16'sh0000, 16'sh0000);
    send_item(CMD_QUERY, 16'shfff0, 16'sh0000);
    send_item(CMD_CLEAR, 16'sh0000, 16'sh0000);
    drain_results();

    random_phase(PHASE_ITEMS);
    send_idle_pct = 84;
    recv_idle_pct = 22;
    random_phase(2 * PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(3 * PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[point_in_polygon_test] OK");
    end else begin
      $display("[point_in_polygon_test] ERROR");
    end
    $finish;
  end

endmodule
